// ===== hw/rtl/i2c_master_byte_engine_macros.svh =====
// assertion macros for the i2c master byte engine checker
// no dependencies; included by the checker file
`ifndef I2C_MASTER_BYTE_ENGINE_MACROS_SVH
`define I2C_MASTER_BYTE_ENGINE_MACROS_SVH

// same-cycle implication, disabled during reset
`define I2C_MBE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("i2c_mbe: check failed");

// next-cycle implication, disabled during reset
`define I2C_MBE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("i2c_mbe: check failed");

`endif

// ===== hw/rtl/i2c_mbe_pkg.sv =====
// shared types and constants for the i2c master byte engine
// no dependencies; used by the top level, the sequencer and the output buffer
`default_nettype none

package i2c_mbe_pkg;

	localparam int BITS_PER_BYTE = 8;

	localparam logic [7:0] DELAY_RST   = 8'd2;
	localparam logic [7:0] TIMEOUT_RST = 8'd250;

	localparam logic [2:0] CMD_NONE     = 3'd0;
	localparam logic [2:0] CMD_START    = 3'd1;
	localparam logic [2:0] CMD_STOP     = 3'd2;
	localparam logic [2:0] CMD_WRITE    = 3'd3;
	localparam logic [2:0] CMD_READ     = 3'd4;
	localparam logic [2:0] CMD_WAIT_ACK = 3'd5;

	localparam logic CFG_DELAY   = 1'b0;
	localparam logic CFG_TIMEOUT = 1'b1;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_START_A,
		PH_START_B,
		PH_STOP_A,
		PH_STOP_B,
		PH_STOP_C,
		PH_WR_LO,
		PH_WR_HI,
		PH_RD_LO,
		PH_RD_HI,
		PH_ACK_LO,
		PH_ACK_HI,
		PH_WA_LO,
		PH_WA_HI,
		PH_WA_POLL
	} phase_t;

	typedef struct packed {
		logic [7:0] delay_ticks;
		logic [7:0] ack_timeout;
	} cfg_t;

	typedef struct packed {
		phase_t     phase;
		logic [7:0] tick_count;
		logic [3:0] bit_count;
		logic [7:0] shift_reg;
		logic [7:0] wait_count;
		logic       ack_choice;
		logic       scl;
		logic       sda;
		logic       drive;
		logic [7:0] rx_hold;
		logic       fail;
	} seq_t;

	typedef struct packed {
		logic       scl;
		logic       sda_level;
		logic       sda_drive;
		logic       busy;
		logic       done;
		logic [7:0] rx_byte;
		logic       ack_failed;
	} res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/i2c_master_byte_engine.sv =====
// a result is registered and offered in the cycle after its tick transfer when the output is free
// throughput: one tick transfer per cycle while tick_stall is low; two results may wait before tick_stall rises
// tick_stall is the registered skid-full flag, so it never depends on res_stall directly
// reset: sequencer idle with scl and sda high and sda driven, delay_ticks 2, ack_timeout 250
// top level of the i2c master byte engine; depends on i2c_mbe_pkg, i2c_mbe_seq, i2c_mbe_obuf
`default_nettype none

module i2c_master_byte_engine (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       tick_valid,
	output logic            tick_stall,
	input  wire logic [2:0] cmd,
	input  wire logic [7:0] tx_byte,
	input  wire logic       send_ack,
	input  wire logic       sda_in,
	output logic            res_valid,
	input  wire logic       res_stall,
	output logic            scl,
	output logic            sda_level,
	output logic            sda_drive,
	output logic            busy_res,
	output logic            done_res,
	output logic [7:0]      rx_byte,
	output logic            ack_failed,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic       cfg_index,
	input  wire logic [7:0] cfg_data
);

	i2c_mbe_pkg::cfg_t cfg_q;
	i2c_mbe_pkg::res_t seq_res;
	i2c_mbe_pkg::res_t out_res;
	logic              step;
	logic              obuf_full;

	assign cfg_ready  = 1'b1;
	assign tick_stall = obuf_full;
	assign step       = tick_valid && !tick_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delay_ticks <= i2c_mbe_pkg::DELAY_RST;
			cfg_q.ack_timeout <= i2c_mbe_pkg::TIMEOUT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				i2c_mbe_pkg::CFG_DELAY:   cfg_q.delay_ticks <= cfg_data;
				i2c_mbe_pkg::CFG_TIMEOUT: cfg_q.ack_timeout <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	i2c_mbe_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.cmd      (cmd),
		.tx_byte  (tx_byte),
		.send_ack (send_ack),
		.sda_in   (sda_in),
		.cfg      (cfg_q),
		.res      (seq_res)
	);

	i2c_mbe_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (step),
		.push_res  (seq_res),
		.full      (obuf_full),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (out_res)
	);

	assign scl        = out_res.scl;
	assign sda_level  = out_res.sda_level;
	assign sda_drive  = out_res.sda_drive;
	assign busy_res   = out_res.busy;
	assign done_res   = out_res.done;
	assign rx_byte    = out_res.rx_byte;
	assign ack_failed = out_res.ack_failed;

endmodule

`default_nettype wire

// ===== hw/rtl/i2c_mbe_seq.sv =====
// bus sequencer: one tick per step, state register plus next-state logic
// depends on i2c_mbe_pkg
`default_nettype none

module i2c_mbe_seq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic [2:0]        cmd,
	input  wire logic [7:0]        tx_byte,
	input  wire logic              send_ack,
	input  wire logic              sda_in,
	input  wire i2c_mbe_pkg::cfg_t cfg,
	output i2c_mbe_pkg::res_t      res
);

	i2c_mbe_pkg::seq_t seq_q;
	i2c_mbe_pkg::seq_t seq_d;

	function automatic i2c_mbe_pkg::seq_t enter_ph(i2c_mbe_pkg::seq_t s,
			i2c_mbe_pkg::phase_t p, logic c, logic d, logic e);
		i2c_mbe_pkg::seq_t r;
		r            = s;
		r.phase      = p;
		r.scl        = c;
		r.sda        = d;
		r.drive      = e;
		r.tick_count = 8'd0;
		return r;
	endfunction

	always_comb begin
		i2c_mbe_pkg::seq_t s;
		logic              done;
		logic [8:0]        tick_inc;

		s        = seq_q;
		done     = 1'b0;
		tick_inc = 9'd0;

		// command dispatch when idle
		if (seq_q.phase == i2c_mbe_pkg::PH_IDLE) begin
			case (cmd)
				i2c_mbe_pkg::CMD_START: begin
					s = enter_ph(s, i2c_mbe_pkg::PH_START_A, 1'b1, 1'b1, 1'b1);
				end
				i2c_mbe_pkg::CMD_STOP: begin
					s = enter_ph(s, i2c_mbe_pkg::PH_STOP_A, 1'b0, 1'b0, 1'b1);
				end
				i2c_mbe_pkg::CMD_WRITE: begin
					s.bit_count = 4'd0;
					s = enter_ph(s, i2c_mbe_pkg::PH_WR_LO, 1'b0, tx_byte[7], 1'b1);
					s.shift_reg = {tx_byte[6:0], 1'b0};
				end
				i2c_mbe_pkg::CMD_READ: begin
					s.bit_count  = 4'd0;
					s.shift_reg  = 8'd0;
					s.ack_choice = send_ack;
					s = enter_ph(s, i2c_mbe_pkg::PH_RD_LO, 1'b0, 1'b1, 1'b0);
				end
				i2c_mbe_pkg::CMD_WAIT_ACK: begin
					s.fail = 1'b0;
					s = enter_ph(s, i2c_mbe_pkg::PH_WA_LO, s.scl, 1'b1, 1'b0);
				end
				default: begin
				end
			endcase
		end

		res.scl       = s.scl;
		res.sda_level = s.sda;
		res.sda_drive = s.drive;
		res.busy      = (s.phase != i2c_mbe_pkg::PH_IDLE);

		if (s.phase == i2c_mbe_pkg::PH_WA_POLL) begin
			if (!sda_in) begin
				s.scl        = 1'b0;
				s.phase      = i2c_mbe_pkg::PH_IDLE;
				s.tick_count = 8'd0;
				done         = 1'b1;
			end else if (s.wait_count >= cfg.ack_timeout) begin
				s.fail = 1'b1;
				s = enter_ph(s, i2c_mbe_pkg::PH_STOP_A, 1'b0, 1'b0, 1'b1);
			end else begin
				s.wait_count = s.wait_count + 8'd1;
			end
		end else if (s.phase != i2c_mbe_pkg::PH_IDLE) begin
			// sample on the first high tick of a read bit
			if (s.phase == i2c_mbe_pkg::PH_RD_HI && s.tick_count == 8'd0) begin
				s.shift_reg = {s.shift_reg[6:0], sda_in};
			end
			tick_inc = {1'b0, s.tick_count} + 9'd1;
			if (tick_inc >= {1'b0, cfg.delay_ticks}) begin
				case (s.phase)
					i2c_mbe_pkg::PH_START_A: begin
						s = enter_ph(s, i2c_mbe_pkg::PH_START_B, 1'b1, 1'b0, 1'b1);
					end
					i2c_mbe_pkg::PH_START_B: begin
						s.scl        = 1'b0;
						s.phase      = i2c_mbe_pkg::PH_IDLE;
						s.tick_count = 8'd0;
						done         = 1'b1;
					end
					i2c_mbe_pkg::PH_STOP_A: begin
						s = enter_ph(s, i2c_mbe_pkg::PH_STOP_B, 1'b1, 1'b0, 1'b1);
					end
					i2c_mbe_pkg::PH_STOP_B: begin
						s = enter_ph(s, i2c_mbe_pkg::PH_STOP_C, 1'b1, 1'b1, 1'b1);
					end
					i2c_mbe_pkg::PH_WR_LO: begin
						s = enter_ph(s, i2c_mbe_pkg::PH_WR_HI, 1'b1, s.sda, 1'b1);
					end
					i2c_mbe_pkg::PH_WR_HI: begin
						s.bit_count = s.bit_count + 4'd1;
						if (s.bit_count >= 4'(i2c_mbe_pkg::BITS_PER_BYTE)) begin
							s.scl        = 1'b0;
							s.phase      = i2c_mbe_pkg::PH_IDLE;
							s.tick_count = 8'd0;
							done         = 1'b1;
						end else begin
							s = enter_ph(s, i2c_mbe_pkg::PH_WR_LO, 1'b0, s.shift_reg[7], 1'b1);
							s.shift_reg = {s.shift_reg[6:0], 1'b0};
						end
					end
					i2c_mbe_pkg::PH_RD_LO: begin
						s = enter_ph(s, i2c_mbe_pkg::PH_RD_HI, 1'b1, 1'b1, 1'b0);
					end
					i2c_mbe_pkg::PH_RD_HI: begin
						s.bit_count = s.bit_count + 4'd1;
						if (s.bit_count >= 4'(i2c_mbe_pkg::BITS_PER_BYTE)) begin
							s = enter_ph(s, i2c_mbe_pkg::PH_ACK_LO, 1'b0, !s.ack_choice, 1'b1);
						end else begin
							s = enter_ph(s, i2c_mbe_pkg::PH_RD_LO, 1'b0, 1'b1, 1'b0);
						end
					end
					i2c_mbe_pkg::PH_ACK_LO: begin
						s = enter_ph(s, i2c_mbe_pkg::PH_ACK_HI, 1'b1, s.sda, 1'b1);
					end
					i2c_mbe_pkg::PH_ACK_HI: begin
						s.scl        = 1'b0;
						s.rx_hold    = s.shift_reg;
						s.phase      = i2c_mbe_pkg::PH_IDLE;
						s.tick_count = 8'd0;
						done         = 1'b1;
					end
					i2c_mbe_pkg::PH_WA_LO: begin
						s = enter_ph(s, i2c_mbe_pkg::PH_WA_HI, 1'b1, 1'b1, 1'b0);
					end
					i2c_mbe_pkg::PH_WA_HI: begin
						s = enter_ph(s, i2c_mbe_pkg::PH_WA_POLL, 1'b1, 1'b1, 1'b0);
						s.wait_count = 8'd0;
					end
					default: begin
						s.phase      = i2c_mbe_pkg::PH_IDLE;
						s.tick_count = 8'd0;
						done         = 1'b1;
					end
				endcase
			end else begin
				s.tick_count = s.tick_count + 8'd1;
			end
		end

		res.done       = done;
		res.rx_byte    = s.rx_hold;
		res.ack_failed = s.fail;
		seq_d          = s;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q.phase      <= i2c_mbe_pkg::PH_IDLE;
			seq_q.tick_count <= 8'd0;
			seq_q.bit_count  <= 4'd0;
			seq_q.shift_reg  <= 8'd0;
			seq_q.wait_count <= 8'd0;
			seq_q.ack_choice <= 1'b0;
			seq_q.scl        <= 1'b1;
			seq_q.sda        <= 1'b1;
			seq_q.drive      <= 1'b1;
			seq_q.rx_hold    <= 8'd0;
			seq_q.fail       <= 1'b0;
		end else if (step) begin
			seq_q <= seq_d;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/i2c_mbe_obuf.sv =====
// result output register with one skid entry
// depends on i2c_mbe_pkg
`default_nettype none

module i2c_mbe_obuf (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire i2c_mbe_pkg::res_t push_res,
	output logic                   full,
	output logic                   res_valid,
	input  wire logic              res_stall,
	output i2c_mbe_pkg::res_t      res
);

	logic              out_vld_q;
	logic              skid_vld_q;
	i2c_mbe_pkg::res_t out_q;
	i2c_mbe_pkg::res_t skid_q;
	logic              out_free;

	assign out_free  = !out_vld_q || !res_stall;
	assign full      = skid_vld_q;
	assign res_valid = out_vld_q;
	assign res       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (out_free) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= push;
			end
		end else if (push) begin
			skid_vld_q <= 1'b1;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_vld_q ? skid_q : push_res;
		end else if (push) begin
			skid_q <= push_res;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/i2c_mbe_chk.sv =====
// port-level checker for the i2c master byte engine, bound to the top level
// depends on i2c_master_byte_engine_macros.svh
`default_nettype none
`include "i2c_master_byte_engine_macros.svh"

module i2c_mbe_chk (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       tick_valid,
	input wire logic       tick_stall,
	input wire logic       res_valid,
	input wire logic       res_stall,
	input wire logic       sda_level,
	input wire logic       sda_drive,
	input wire logic       busy_res,
	input wire logic       done_res,
	input wire logic [7:0] rx_byte
);

	// input side only stalls while a result is pending
	`I2C_MBE_ASSERT_NOW(a_stall_has_result, clk, arst_n, tick_stall, res_valid)

	// a transfer into an empty output shows a result next cycle
	`I2C_MBE_ASSERT_NEXT(a_transfer_lands, clk, arst_n,
		tick_valid && !tick_stall && !res_valid, res_valid)

	// a finishing tick belongs to a running command
	`I2C_MBE_ASSERT_NOW(a_done_busy, clk, arst_n, res_valid && done_res, busy_res)

	// released sda reads as high
	`I2C_MBE_ASSERT_NOW(a_release_high, clk, arst_n, res_valid && !sda_drive, sda_level)

	// a stalled result holds
	`I2C_MBE_ASSERT_NEXT(a_hold_stalled, clk, arst_n, res_valid && res_stall,
		res_valid && $stable(rx_byte) && $stable(done_res))

endmodule

bind i2c_master_byte_engine i2c_mbe_chk u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.tick_valid (tick_valid),
	.tick_stall (tick_stall),
	.res_valid  (res_valid),
	.res_stall  (res_stall),
	.sda_level  (sda_level),
	.sda_drive  (sda_drive),
	.busy_res   (busy_res),
	.done_res   (done_res),
	.rx_byte    (rx_byte)
);

`default_nettype wire

// ===== tb/tb_i2c_master_byte_engine.sv =====
// testbench for the i2c master byte engine: directed and random bus frames, one result per tick
// each result is checked against a cycle-level predictor of the line sequencer
// depends on i2c_mbe_pkg and i2c_master_byte_engine
`default_nettype none

module tb_i2c_master_byte_engine;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       tick_valid = 1'b0;
	logic       tick_stall;
	logic [2:0] cmd = i2c_mbe_pkg::CMD_NONE;
	logic [7:0] tx_byte = 8'h00;
	logic       send_ack = 1'b0;
	logic       sda_in = 1'b1;
	logic       res_valid;
	logic       res_stall = 1'b0;
	logic       scl;
	logic       sda_level;
	logic       sda_drive;
	logic       busy_res;
	logic       done_res;
	logic [7:0] rx_byte;
	logic       ack_failed;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic       cfg_index = i2c_mbe_pkg::CFG_DELAY;
	logic [7:0] cfg_data = 8'h00;

	i2c_master_byte_engine DUT (
		.clk(clk),
		.arst_n(arst_n),
		.tick_valid(tick_valid),
		.tick_stall(tick_stall),
		.cmd(cmd),
		.tx_byte(tx_byte),
		.send_ack(send_ack),
		.sda_in(sda_in),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.scl(scl),
		.sda_level(sda_level),
		.sda_drive(sda_drive),
		.busy_res(busy_res),
		.done_res(done_res),
		.rx_byte(rx_byte),
		.ack_failed(ack_failed),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

	// predictor state
	i2c_mbe_pkg::phase_t bus_phase;
	logic [7:0] bus_ticks;
	logic [3:0] bus_bits;
	logic [7:0] bus_shift;
	logic [7:0] bus_polls;
	logic       bus_ack_sel;
	logic       bus_scl;
	logic       bus_sda;
	logic       bus_drive;
	logic [7:0] bus_rx;
	logic       bus_fail;
	logic       bus_done;
	logic [7:0] set_delay;
	logic [7:0] set_timeout;

	i2c_mbe_pkg::res_t pending_lines[$];
	int   err_count = 0;
	int   ticks_sent = 0;
	int   burst_left = 0;
	int   rx_cycle = 0;
	int   rx_mode = 0;

	function automatic void bus_reset();
		set_delay = i2c_mbe_pkg::DELAY_RST;
		set_timeout = i2c_mbe_pkg::TIMEOUT_RST;
		bus_phase = i2c_mbe_pkg::PH_IDLE;
		bus_ticks = 8'h00;
		bus_bits = 4'h0;
		bus_shift = 8'h00;
		bus_polls = 8'h00;
		bus_ack_sel = 1'b0;
		bus_scl = 1'b1;
		bus_sda = 1'b1;
		bus_drive = 1'b1;
		bus_rx = 8'h00;
		bus_fail = 1'b0;
		bus_done = 1'b0;
	endfunction

	function automatic void bus_enter(i2c_mbe_pkg::phase_t p, logic c, logic d, logic e);
		bus_phase = p;
		bus_scl = c;
		bus_sda = d;
		bus_drive = e;
		bus_ticks = 8'h00;
	endfunction

	function automatic void bus_finish();
		bus_phase = i2c_mbe_pkg::PH_IDLE;
		bus_ticks = 8'h00;
		bus_done = 1'b1;
	endfunction

	function automatic void bus_next_bit();
		bus_enter(i2c_mbe_pkg::PH_WR_LO, 1'b0, bus_shift[7], 1'b1);
		bus_shift = {bus_shift[6:0], 1'b0};
	endfunction

	function automatic i2c_mbe_pkg::res_t bus_tick(logic [2:0] c, logic [7:0] tx, logic sa,
			logic sd);
		i2c_mbe_pkg::res_t r;
		bus_done = 1'b0;
		if (bus_phase == i2c_mbe_pkg::PH_IDLE) begin
			case (c)
				i2c_mbe_pkg::CMD_START: bus_enter(i2c_mbe_pkg::PH_START_A, 1'b1, 1'b1, 1'b1);
				i2c_mbe_pkg::CMD_STOP: bus_enter(i2c_mbe_pkg::PH_STOP_A, 1'b0, 1'b0, 1'b1);
				i2c_mbe_pkg::CMD_WRITE: begin
					bus_bits = 4'h0;
					bus_shift = tx;
					bus_next_bit();
				end
				i2c_mbe_pkg::CMD_READ: begin
					bus_bits = 4'h0;
					bus_shift = 8'h00;
					bus_ack_sel = sa;
					bus_enter(i2c_mbe_pkg::PH_RD_LO, 1'b0, 1'b1, 1'b0);
				end
				i2c_mbe_pkg::CMD_WAIT_ACK: begin
					bus_fail = 1'b0;
					bus_enter(i2c_mbe_pkg::PH_WA_LO, bus_scl, 1'b1, 1'b0);
				end
				default: ;
			endcase
		end
		r.scl = bus_scl;
		r.sda_level = bus_sda;
		r.sda_drive = bus_drive;
		r.busy = (bus_phase != i2c_mbe_pkg::PH_IDLE);
		if (bus_phase == i2c_mbe_pkg::PH_WA_POLL) begin
			if (!sd) begin
				bus_scl = 1'b0;
				bus_finish();
			end else if (bus_polls >= set_timeout) begin
				bus_fail = 1'b1;
				bus_enter(i2c_mbe_pkg::PH_STOP_A, 1'b0, 1'b0, 1'b1);
			end else begin
				bus_polls = bus_polls + 8'd1;
			end
		end else if (bus_phase != i2c_mbe_pkg::PH_IDLE) begin
			if (bus_phase == i2c_mbe_pkg::PH_RD_HI && bus_ticks == 8'h00)
				bus_shift = {bus_shift[6:0], sd};
			if (int'(bus_ticks) + 1 >= int'(set_delay)) begin
				case (bus_phase)
					i2c_mbe_pkg::PH_START_A:
						bus_enter(i2c_mbe_pkg::PH_START_B, 1'b1, 1'b0, 1'b1);
					i2c_mbe_pkg::PH_START_B: begin
						bus_scl = 1'b0;
						bus_finish();
					end
					i2c_mbe_pkg::PH_STOP_A:
						bus_enter(i2c_mbe_pkg::PH_STOP_B, 1'b1, 1'b0, 1'b1);
					i2c_mbe_pkg::PH_STOP_B:
						bus_enter(i2c_mbe_pkg::PH_STOP_C, 1'b1, 1'b1, 1'b1);
					i2c_mbe_pkg::PH_WR_LO:
						bus_enter(i2c_mbe_pkg::PH_WR_HI, 1'b1, bus_sda, 1'b1);
					i2c_mbe_pkg::PH_WR_HI: begin
						bus_bits = bus_bits + 4'd1;
						if (bus_bits >= i2c_mbe_pkg::BITS_PER_BYTE) begin
							bus_scl = 1'b0;
							bus_finish();
						end else begin
							bus_next_bit();
						end
					end
					i2c_mbe_pkg::PH_RD_LO:
						bus_enter(i2c_mbe_pkg::PH_RD_HI, 1'b1, 1'b1, 1'b0);
					i2c_mbe_pkg::PH_RD_HI: begin
						bus_bits = bus_bits + 4'd1;
						if (bus_bits >= i2c_mbe_pkg::BITS_PER_BYTE)
							bus_enter(i2c_mbe_pkg::PH_ACK_LO, 1'b0, !bus_ack_sel, 1'b1);
						else
							bus_enter(i2c_mbe_pkg::PH_RD_LO, 1'b0, 1'b1, 1'b0);
					end
					i2c_mbe_pkg::PH_ACK_LO:
						bus_enter(i2c_mbe_pkg::PH_ACK_HI, 1'b1, bus_sda, 1'b1);
					i2c_mbe_pkg::PH_ACK_HI: begin
						bus_scl = 1'b0;
						bus_rx = bus_shift;
						bus_finish();
					end
					i2c_mbe_pkg::PH_WA_LO:
						bus_enter(i2c_mbe_pkg::PH_WA_HI, 1'b1, 1'b1, 1'b0);
					i2c_mbe_pkg::PH_WA_HI: begin
						bus_enter(i2c_mbe_pkg::PH_WA_POLL, 1'b1, 1'b1, 1'b0);
						bus_polls = 8'h00;
					end
					default: bus_finish();
				endcase
			end else begin
				bus_ticks = bus_ticks + 8'd1;
			end
		end
		r.done = bus_done;
		r.rx_byte = bus_rx;
		r.ack_failed = bus_fail;
		return r;
	endfunction

	// slave side: ack after hold high polls while the master polls, random line otherwise
	function automatic logic slave_sda(int hold);
		if (bus_phase == i2c_mbe_pkg::PH_WA_POLL)
			return (int'(bus_polls) >= hold) ? 1'b0 : 1'b1;
		return 1'($urandom);
	endfunction

	function automatic int pick_hold();
		if ($urandom_range(0, 9) == 0)
			return 1000;
		return $urandom_range(0, 4);
	endfunction

	task automatic send_tick(input logic [2:0] c, input logic [7:0] tx, input logic sa,
			input logic sd);
		tick_valid <= 1'b1;
		cmd <= c;
		tx_byte <= tx;
		send_ack <= sa;
		sda_in <= sd;
		@(posedge clk);
		while (tick_stall) @(posedge clk);
		pending_lines.push_back(bus_tick(c, tx, sa, sd));
		ticks_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			tick_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(0, 12);
		end
	endtask

	task automatic run_cmd(input logic [2:0] c, input logic [7:0] tx, input logic sa,
			input int hold, input bit noisy);
		send_tick(c, tx, sa, slave_sda(hold));
		while (bus_phase != i2c_mbe_pkg::PH_IDLE)
			send_tick(noisy ? 3'($urandom_range(0, 7)) : i2c_mbe_pkg::CMD_NONE, 8'($urandom),
				1'($urandom), slave_sda(hold));
	endtask

	task automatic settle_bus();
		while (bus_phase != i2c_mbe_pkg::PH_IDLE)
			send_tick(i2c_mbe_pkg::CMD_NONE, 8'($urandom), 1'($urandom), slave_sda(0));
		if (tick_valid) tick_valid <= 1'b0;
		while (pending_lines.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] val);
		settle_bus();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == i2c_mbe_pkg::CFG_DELAY)
			set_delay = val;
		else
			set_timeout = val;
	endtask

	task automatic test_reset_settings();
		run_cmd(i2c_mbe_pkg::CMD_START, 8'h00, 1'b0, 0, 1'b0);
		run_cmd(i2c_mbe_pkg::CMD_WRITE, 8'hA5, 1'b0, 0, 1'b1);
		run_cmd(i2c_mbe_pkg::CMD_WAIT_ACK, 8'h00, 1'b0, 2, 1'b0);
		run_cmd(i2c_mbe_pkg::CMD_WRITE, 8'h00, 1'b0, 0, 1'b0);
		run_cmd(i2c_mbe_pkg::CMD_WAIT_ACK, 8'h00, 1'b0, 0, 1'b1);
		run_cmd(i2c_mbe_pkg::CMD_WRITE, 8'hFF, 1'b1, 0, 1'b0);
		run_cmd(i2c_mbe_pkg::CMD_WAIT_ACK, 8'hFF, 1'b1, 1000, 1'b0);
		run_cmd(i2c_mbe_pkg::CMD_READ, 8'h00, 1'b1, 0, 1'b1);
		run_cmd(i2c_mbe_pkg::CMD_READ, 8'hFF, 1'b0, 0, 1'b0);
		run_cmd(i2c_mbe_pkg::CMD_STOP, 8'h00, 1'b0, 0, 1'b0);
		run_cmd(3'd6, 8'h3C, 1'b1, 0, 1'b0);
		run_cmd(3'd7, 8'hC3, 1'b0, 0, 1'b0);
		run_cmd(i2c_mbe_pkg::CMD_NONE, 8'h00, 1'b0, 0, 1'b0);
	endtask

	task automatic test_zero_settings();
		write_reg(i2c_mbe_pkg::CFG_DELAY, 8'd0);
		write_reg(i2c_mbe_pkg::CFG_TIMEOUT, 8'd0);
		run_cmd(i2c_mbe_pkg::CMD_START, 8'h00, 1'b0, 0, 1'b0);
		run_cmd(i2c_mbe_pkg::CMD_WRITE, 8'h5A, 1'b0, 0, 1'b1);
		run_cmd(i2c_mbe_pkg::CMD_WAIT_ACK, 8'h00, 1'b0, 1000, 1'b0);
		run_cmd(i2c_mbe_pkg::CMD_READ, 8'h00, 1'b1, 0, 1'b0);
		run_cmd(i2c_mbe_pkg::CMD_STOP, 8'h00, 1'b0, 0, 1'b0);
	endtask

	task automatic test_extreme_settings();
		write_reg(i2c_mbe_pkg::CFG_DELAY, 8'd255);
		run_cmd(i2c_mbe_pkg::CMD_START, 8'h00, 1'b0, 0, 1'b1);
	endtask

	task automatic run_frame();
		int n;
		n = $urandom_range(0, 3);
		run_cmd(i2c_mbe_pkg::CMD_START, 8'($urandom), 1'($urandom), 0, 1'($urandom));
		run_cmd(i2c_mbe_pkg::CMD_WRITE, 8'($urandom), 1'($urandom), 0, 1'($urandom));
		run_cmd(i2c_mbe_pkg::CMD_WAIT_ACK, 8'($urandom), 1'($urandom), pick_hold(),
			1'($urandom));
		repeat (n) begin
			if ($urandom_range(0, 1) == 0) begin
				run_cmd(i2c_mbe_pkg::CMD_WRITE, 8'($urandom), 1'($urandom), 0, 1'($urandom));
				run_cmd(i2c_mbe_pkg::CMD_WAIT_ACK, 8'($urandom), 1'($urandom), pick_hold(),
					1'($urandom));
			end else begin
				run_cmd(i2c_mbe_pkg::CMD_READ, 8'($urandom), 1'($urandom), 0, 1'($urandom));
			end
		end
		run_cmd(i2c_mbe_pkg::CMD_STOP, 8'($urandom), 1'($urandom), 0, 1'($urandom));
	endtask

	task automatic test_random_traffic();
		int goal;
		for (int k = 0; k < 5; k++) begin
			write_reg(i2c_mbe_pkg::CFG_DELAY, (k == 2) ? 8'd1 : 8'($urandom_range(1, 4)));
			write_reg(i2c_mbe_pkg::CFG_TIMEOUT, (k == 4) ? 8'd1 : 8'($urandom_range(1, 8)));
			goal = ticks_sent + 60;
			while (ticks_sent < goal) begin
				if ($urandom_range(0, 4) != 0) begin
					run_frame();
				end else begin
					repeat ($urandom_range(1, 6))
						run_cmd(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom),
							pick_hold(), 1'b1);
				end
				if ($urandom_range(0, 9) == 0)
					settle_bus();
			end
		end
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_count++;
		end
	endtask

	always @(posedge clk) begin : result_check
		i2c_mbe_pkg::res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_lines.size() == 0) begin
				$error("result transfer with nothing expected");
				err_count++;
			end else begin
				want = pending_lines.pop_front();
				check_field("scl", want.scl, scl);
				check_field("sda_level", want.sda_level, sda_level);
				check_field("sda_drive", want.sda_drive, sda_drive);
				check_field("busy_res", want.busy, busy_res);
				check_field("done_res", want.done, done_res);
				check_field("rx_byte", want.rx_byte, rx_byte);
				check_field("ack_failed", want.ack_failed, ack_failed);
			end
		end
	end

	// receiver stall pattern, mode chosen at random among no stalls, random stalls and periodic stalls
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1;
		if (rx_cycle % 512 == 0)
			rx_mode <= $urandom_range(0, 2);
		case (rx_mode)
			0: res_stall <= 1'b0;
			1: res_stall <= ($urandom_range(0, 9) < 3);
			default: res_stall <= (rx_cycle % 7 < 3);
		endcase
	end

	initial begin
		int guard;
		bus_reset();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_settings();
		test_zero_settings();
		test_extreme_settings();
		test_random_traffic();
		while (bus_phase != i2c_mbe_pkg::PH_IDLE)
			send_tick(i2c_mbe_pkg::CMD_NONE, 8'($urandom), 1'($urandom), slave_sda(0));
		if (tick_valid) tick_valid <= 1'b0;
		guard = 0;
		while (pending_lines.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (8) @(posedge clk);
		if (pending_lines.size() != 0) begin
			$error("%0d expected results never arrived", pending_lines.size());
			err_count++;
		end
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire
